FILE: hdl/scs_pkg.sv
// Shared types and constants for the shortest common supersequence core.
// No dependencies; used by the top level, scs_ctrl and scs_datapath.
package scs_pkg;

  localparam int MaxLenDefault = 32;

  localparam logic [1:0] OpLoadFirst  = 2'd0;
  localparam logic [1:0] OpLoadSecond = 2'd1;
  localparam logic [1:0] OpRun        = 2'd2;
  localparam logic [1:0] OpUnused     = 2'd3;

  localparam logic [1:0] DirSecond = 2'd1;
  localparam logic [1:0] DirBoth   = 2'd2;
  localparam logic [1:0] DirFirst  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_first;
    logic load_second;
    logic fill_start;
    logic fill_step;
    logic trace_start;
    logic trace_step;
    logic emit_start;
    logic emit_step;
    logic clear;
  } scs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_done;
    logic trace_done;
    logic emit_done;
    logic empty;
  } scs_sts_t;

endpackage

FILE: hdl/shortest_common_supersequence_core.sv
// Top level of the shortest common supersequence core.
// Depends on scs_pkg, scs_ctrl, scs_datapath and scs_ram.
//
// Load words (opcode 0 or 1) append a byte to the first or second string and
// are taken one per cycle; a load to a full string is dropped and sets the
// overflow flag reported with the next run's output. A run word (opcode 2)
// fills the direction table one cell per cycle, then traces back through the
// registered direction RAM, issuing an address and then using the read for
// each symbol, and finally emits the supersequence in forward order from a
// result stack RAM, one word at a time, marking the final symbol with tlast.
// No input is taken between a run word and its final output word.
// A run with both strings empty emits nothing. Opcode 3 is ignored.
module shortest_common_supersequence_core #(
  parameter int MaxLen = scs_pkg::MaxLenDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [1:0] opcode, [9:2] symbol, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_symbol
  output logic        m_tlast,
  output logic        m_tuser    // [0] overflow
);

  scs_pkg::scs_cmd_t cmd;
  scs_pkg::scs_sts_t sts;
  logic              load_ovf;
  logic              first_full, second_full;
  logic [$clog2(MaxLen+1)-1:0] n1_cnt, n2_cnt;

  // Shadow length counters used only to decide drops.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      n1_cnt <= '0;
      n2_cnt <= '0;
    end else begin
      if (cmd.load_first) begin
        n1_cnt <= n1_cnt + 1'b1;
      end
      if (cmd.load_second) begin
        n2_cnt <= n2_cnt + 1'b1;
      end
    end
  end
  assign first_full  = (n1_cnt == ($clog2(MaxLen+1))'(MaxLen));
  assign second_full = (n2_cnt == ($clog2(MaxLen+1))'(MaxLen));

  scs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .in_op(s_tdata[1:0]), .first_full(first_full), .second_full(second_full),
    .out_valid(m_tvalid), .out_ready(m_tready), .cmd(cmd), .sts(sts),
    .load_ovf(load_ovf)
  );

  scs_datapath #(.MaxLen(MaxLen)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .in_sym(s_tdata[9:2]),
    .out_sym(m_tdata), .out_last(m_tlast), .out_ovf(m_tuser),
    .load_ovf(load_ovf)
  );

  // The block never takes input while output words are pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input ready during output");

  // A stalled output word holds its last marker.
  a_last_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tlast))
    else $error("output word changed under stall");

  // A dropped load never advances a full string.
  a_drop: assert property (@(posedge clk) disable iff (rst)
    load_ovf |-> !cmd.load_first && !cmd.load_second)
    else $error("dropped load was stored");

endmodule

FILE: hdl/scs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module scs_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/scs_datapath.sv
// Datapath: string stores, length row, direction table, traceback and result stack.
// Depends on scs_pkg and scs_ram.
module scs_datapath #(
  parameter int MaxLen = scs_pkg::MaxLenDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  scs_pkg::scs_cmd_t cmd,
  output scs_pkg::scs_sts_t sts,
  input  logic [7:0]        in_sym,
  output logic [7:0]        out_sym,
  output logic              out_last,
  output logic              out_ovf,
  input  logic              load_ovf
);

  localparam int Side = MaxLen + 1;
  localparam int LW   = $clog2(MaxLen + 1);
  localparam int AW   = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int SW   = $clog2(2 * MaxLen);
  localparam int DW   = $clog2(Side * Side);
  localparam int VW   = $clog2(2 * MaxLen + 1);

  logic [LW-1:0] first_length, second_length;
  logic          dropped_flag;
  logic [LW-1:0] ci, cj;          // fill cursor, 1-based
  logic [LW-1:0] ti, tj;          // traceback cursor
  logic [VW-1:0] count;
  logic [VW-1:0] ecnt;
  logic          ovf_snap;

  // Previous row in flip-flops; entry k holds column k+1. Column zero of any
  // row i is simply i, so it is never stored.
  logic [VW-1:0] prev_row [MaxLen];
  logic [VW-1:0] left_len;

  // Second string held in registers so fill reads it at the walking column.
  logic [7:0] second_reg [MaxLen];
  logic [7:0] first_rd;
  logic [1:0] dir_rd;
  logic [7:0] stack_rd;

  logic          dir_we;
  logic [DW-1:0] dir_waddr, dir_raddr;
  logic [1:0]    dir_wdata;
  logic          stk_we;
  logic [SW-1:0] stk_addr_w, stk_addr_r;
  logic [7:0]    stk_wdata;
  logic [AW-1:0] first_raddr;
  logic [AW-1:0] first_waddr;

  // Traceback runs in two phases per symbol: address issue, then use.
  logic tphase;

  assign first_waddr = first_length[AW-1:0];

  scs_ram #(.Width(8), .Depth(MaxLen)) u_first (
    .clk(clk), .we(cmd.load_first), .waddr(first_waddr), .wdata(in_sym),
    .raddr(first_raddr), .rdata(first_rd)
  );

  scs_ram #(.Width(2), .Depth(Side * Side)) u_dir (
    .clk(clk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
    .raddr(dir_raddr), .rdata(dir_rd)
  );

  scs_ram #(.Width(8), .Depth(2 * MaxLen)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_addr_w), .wdata(stk_wdata),
    .raddr(stk_addr_r), .rdata(stack_rd)
  );

  // Fill cell computation at (ci, cj). The first-string symbol of row ci is
  // read with address ci-1 all through the row, so it is valid from column one.
  logic [7:0]    b_sym;
  logic [VW-1:0] diag_len, up_len, cell_len;
  logic [1:0]    cell_dir;
  logic          cj_zero;

  assign cj_zero  = (cj == '0);
  assign b_sym    = cj_zero ? 8'd0 : second_reg[AW'(cj - LW'(1))];
  assign diag_len = (cj == LW'(1)) ? VW'(ci - LW'(1)) : prev_row[AW'(cj - LW'(2))];
  assign up_len   = prev_row[AW'(cj - LW'(1))];

  always_comb begin
    if (cj_zero) begin
      cell_len = VW'(ci);
      cell_dir = scs_pkg::DirFirst;
    end else if (first_rd == b_sym) begin
      cell_len = diag_len + VW'(1);
      cell_dir = scs_pkg::DirBoth;
    end else if (up_len < left_len) begin
      cell_len = up_len + VW'(1);
      cell_dir = scs_pkg::DirFirst;
    end else begin
      cell_len = left_len + VW'(1);
      cell_dir = scs_pkg::DirSecond;
    end
  end

  // The finished cell is written back one column behind so the diagonal value
  // of the next column is still the previous row's.
  logic [VW-1:0] hold_len;

  logic [1:0] tdir;
  always_comb begin
    if (ti == '0) begin
      tdir = scs_pkg::DirSecond;
    end else if (tj == '0) begin
      tdir = scs_pkg::DirFirst;
    end else begin
      tdir = dir_rd;
    end
  end

  always_comb begin
    dir_we     = 1'b0;
    dir_waddr  = DW'(ci) * DW'(Side) + DW'(cj);
    dir_wdata  = cell_dir;
    dir_raddr  = DW'(ti) * DW'(Side) + DW'(tj);
    first_raddr = AW'(ci - LW'(1));
    if (cmd.trace_step) begin
      first_raddr = AW'(ti - LW'(1));
    end
    if (cmd.fill_step) begin
      dir_we = (ci != '0);
    end
    stk_we     = cmd.trace_step && tphase;
    stk_addr_w = SW'(count);
    stk_wdata  = (tdir == scs_pkg::DirSecond) ? second_reg[AW'(tj - LW'(1))] : first_rd;
    stk_addr_r = SW'(ecnt - VW'(1));
    if (cmd.emit_step) begin
      stk_addr_r = SW'(ecnt - VW'(2));
    end
  end

  // An empty first string still walks one row so the fill always ends.
  assign sts.fill_done  = (cj == second_length) && (ci >= first_length);
  assign sts.trace_done = (ti == '0) && (tj == '0);
  assign sts.emit_done  = (ecnt == VW'(1));
  assign sts.empty      = (first_length == '0) && (second_length == '0);

  assign out_sym  = stack_rd;
  assign out_last = (ecnt == VW'(1));
  assign out_ovf  = ovf_snap;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_length  <= '0;
      second_length <= '0;
      dropped_flag  <= 1'b0;
      tphase        <= 1'b0;
    end else begin
      if (load_ovf) begin
        dropped_flag <= 1'b1;
      end
      if (cmd.load_first) begin
        first_length <= first_length + LW'(1);
      end
      if (cmd.load_second) begin
        second_reg[AW'(second_length)] <= in_sym;
        second_length <= second_length + LW'(1);
      end
      if (cmd.fill_start) begin
        for (int k = 0; k < MaxLen; k++) begin
          prev_row[k] <= VW'(k + 1);
        end
        ci <= LW'(1);
        cj <= '0;
        ovf_snap <= dropped_flag;
      end
      if (cmd.fill_step) begin
        if (cj > LW'(1)) begin
          prev_row[AW'(cj - LW'(2))] <= hold_len;
        end
        hold_len <= cell_len;
        left_len <= cell_len;
        if (cj == second_length) begin
          if (!cj_zero) begin
            prev_row[AW'(cj - LW'(1))] <= cell_len;
          end
          cj <= '0;
          ci <= ci + LW'(1);
        end else begin
          cj <= cj + LW'(1);
        end
      end
      if (cmd.trace_start) begin
        ti     <= first_length;
        tj     <= second_length;
        count  <= '0;
        tphase <= 1'b0;
      end
      if (cmd.trace_step) begin
        tphase <= !tphase;
        if (tphase) begin
          count <= count + VW'(1);
          if (tdir != scs_pkg::DirSecond) begin
            ti <= ti - LW'(1);
          end
          if (tdir != scs_pkg::DirFirst) begin
            tj <= tj - LW'(1);
          end
        end
      end
      if (cmd.emit_start) begin
        ecnt <= count;
      end
      if (cmd.emit_step) begin
        ecnt <= ecnt - VW'(1);
      end
      if (cmd.clear) begin
        first_length  <= '0;
        second_length <= '0;
        dropped_flag  <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/scs_ctrl.sv
// Controller state machine: accepts words, sequences fill, traceback and output.
// Depends on scs_pkg.
module scs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic              first_full,
  input  logic              second_full,
  output logic              out_valid,
  input  logic              out_ready,
  output scs_pkg::scs_cmd_t cmd,
  input  scs_pkg::scs_sts_t sts,
  output logic              load_ovf
);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StFill0 = 6'b000010,
    StFill  = 6'b000100,
    StTrace = 6'b001000,
    StPre   = 6'b010000,
    StEmit  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   acc;

  assign in_ready  = (state == StIdle);
  assign acc       = in_valid && in_ready;
  assign out_valid = (state == StEmit);

  always_comb begin
    cmd = '0;
    load_ovf = 1'b0;
    state_next = state;
    case (state)
      StIdle: begin
        if (acc) begin
          case (in_op)
            scs_pkg::OpLoadFirst: begin
              cmd.load_first = !first_full;
              load_ovf = first_full;
            end
            scs_pkg::OpLoadSecond: begin
              cmd.load_second = !second_full;
              load_ovf = second_full;
            end
            scs_pkg::OpRun: begin
              if (sts.empty) begin
                cmd.clear = 1'b1;
              end else begin
                cmd.fill_start = 1'b1;
                state_next = StFill0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StFill0: begin
        // First-string symbol read for row one is in flight.
        state_next = StFill;
      end
      StFill: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_done) begin
          cmd.trace_start = 1'b1;
          state_next = StTrace;
        end
      end
      StTrace: begin
        if (sts.trace_done) begin
          cmd.emit_start = 1'b1;
          state_next = StPre;
        end else begin
          cmd.trace_step = 1'b1;
        end
      end
      StPre: begin
        state_next = StEmit;
      end
      StEmit: begin
        if (out_ready) begin
          if (sts.emit_done) begin
            cmd.clear = 1'b1;
            state_next = StIdle;
          end else begin
            cmd.emit_step = 1'b1;
            state_next = StPre;
          end
        end
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: tb/testbench.sv
// Testbench for the shortest common supersequence core: loads two byte strings,
// runs the engine and compares every output word with a built-in predictor.
// Depends on scs_pkg and shortest_common_supersequence_core.
module testbench;

  localparam int MaxLen = scs_pkg::MaxLenDefault;
  localparam int Side = MaxLen + 1;
  localparam int StallLimit = 20000;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
    logic       overflow;
  } scs_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  shortest_common_supersequence_core #(.MaxLen(MaxLen)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  always #10 clk = ~clk;

  // Predictor state: the two strings, their lengths and the dropped flag.
  logic [7:0] first_str[MaxLen];
  logic [7:0] second_str[MaxLen];
  int         first_len = 0;
  int         second_len = 0;
  bit         dropped = 1'b0;

  scs_word_t  expected_words[$];
  int         errors = 0;
  int         words_checked = 0;
  int         runs_sent = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         idle_cycles = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Builds the supersequence of the current strings and queues its words.
  task automatic predict_supersequence();
    logic [6:0] lens[Side][Side];
    logic [1:0] dirs[Side][Side];
    logic [7:0] rev[2*MaxLen];
    int i, j, n;
    logic [1:0] d;
    scs_word_t w;
    n = 0;
    for (j = 0; j <= second_len; j++) begin
      lens[0][j] = 7'(j);
      dirs[0][j] = scs_pkg::DirSecond;
    end
    for (i = 1; i <= first_len; i++) begin
      lens[i][0] = 7'(i);
      dirs[i][0] = scs_pkg::DirFirst;
      for (j = 1; j <= second_len; j++) begin
        if (first_str[i-1] == second_str[j-1]) begin
          lens[i][j] = lens[i-1][j-1] + 7'd1;
          dirs[i][j] = scs_pkg::DirBoth;
        end else if (lens[i-1][j] < lens[i][j-1]) begin
          lens[i][j] = lens[i-1][j] + 7'd1;
          dirs[i][j] = scs_pkg::DirFirst;
        end else begin
          lens[i][j] = lens[i][j-1] + 7'd1;
          dirs[i][j] = scs_pkg::DirSecond;
        end
      end
    end
    i = first_len;
    j = second_len;
    while ((i > 0 || j > 0) && n < 2 * MaxLen) begin
      d = dirs[i][j];
      if (i == 0) d = scs_pkg::DirSecond;
      else if (j == 0) d = scs_pkg::DirFirst;
      if (d == scs_pkg::DirBoth) begin
        rev[n++] = first_str[i-1];
        i--;
        j--;
      end else if (d == scs_pkg::DirFirst) begin
        rev[n++] = first_str[i-1];
        i--;
      end else begin
        rev[n++] = second_str[j-1];
        j--;
      end
    end
    for (int k = 0; k < n; k++) begin
      w.symbol = rev[n-1-k];
      w.last = (k + 1 == n);
      w.overflow = dropped;
      expected_words.push_back(w);
    end
    first_len = 0;
    second_len = 0;
    dropped = 1'b0;
  endtask

  // Sends one word, with random idle cycles ahead of it, and updates the
  // predictor once the word is accepted. Valid stays high after acceptance
  // until the next idle cycle, the next word or a drain drops it.
  task automatic send_word(input logic [1:0] op, input logic [7:0] sym);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, sym, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    case (op)
      scs_pkg::OpLoadFirst: begin
        if (first_len < MaxLen) first_str[first_len++] = sym;
        else dropped = 1'b1;
      end
      scs_pkg::OpLoadSecond: begin
        if (second_len < MaxLen) second_str[second_len++] = sym;
        else dropped = 1'b1;
      end
      scs_pkg::OpRun: begin
        predict_supersequence();
        runs_sent++;
      end
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Receiver: random backpressure and the check of each accepted word.
  always @(posedge clk) begin
    scs_word_t w;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        words_checked++;
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", m_tdata));
        end else begin
          w = expected_words.pop_front();
          if (m_tdata !== w.symbol)
            report_mismatch($sformatf("symbol %h, want %h", m_tdata, w.symbol));
          if (m_tlast !== w.last)
            report_mismatch($sformatf("tlast %b, want %b", m_tlast, w.last));
          if (m_tuser !== w.overflow)
            report_mismatch($sformatf("overflow %b, want %b", m_tuser, w.overflow));
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Watchdog expired with %0d words outstanding", expected_words.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic load_pair(input int n1, input int n2, input int alphabet);
    for (int k = 0; k < n1; k++)
      send_word(scs_pkg::OpLoadFirst, 8'($urandom_range(alphabet)));
    for (int k = 0; k < n2; k++)
      send_word(scs_pkg::OpLoadSecond, 8'($urandom_range(alphabet)));
  endtask

  task automatic test_directed();
    send_word(scs_pkg::OpRun, 8'h00);          // both strings empty
    send_word(scs_pkg::OpLoadFirst, 8'h00);    // first string only
    send_word(scs_pkg::OpLoadFirst, 8'hFF);
    send_word(scs_pkg::OpRun, 8'hFF);
    send_word(scs_pkg::OpLoadSecond, 8'hAA);   // second string only
    send_word(scs_pkg::OpRun, 8'h55);
    send_word(scs_pkg::OpLoadFirst, 8'h41);    // equal single symbols
    send_word(scs_pkg::OpUnused, 8'h77);       // unused opcode
    send_word(scs_pkg::OpLoadSecond, 8'h41);
    send_word(scs_pkg::OpRun, 8'h00);
    send_word(scs_pkg::OpLoadFirst, 8'h55);    // different symbols, tie case
    send_word(scs_pkg::OpLoadSecond, 8'hAA);
    send_word(scs_pkg::OpRun, 8'h00);
    wait_drained();
  endtask

  // Full strings plus dropped loads on both sides.
  task automatic test_overflow();
    load_pair(MaxLen + 1, MaxLen + 1, 3);
    send_word(scs_pkg::OpRun, 8'h00);
    load_pair(MaxLen, 3, 255);
    send_word(scs_pkg::OpRun, 8'h00);
    load_pair(2, MaxLen + 2, 1);
    send_word(scs_pkg::OpRun, 8'h00);
  endtask

  task automatic test_random(input int n_runs);
    int n1, n2;
    for (int r = 0; r < n_runs; r++) begin
      n1 = ($urandom_range(9) == 0) ? $urandom_range(MaxLen) : $urandom_range(6);
      n2 = ($urandom_range(9) == 0) ? $urandom_range(MaxLen) : $urandom_range(6);
      load_pair(n1, n2, ($urandom_range(1) == 1) ? 255 : 3);
      if ($urandom_range(15) == 0)
        send_word(scs_pkg::OpUnused, 8'($urandom_range(255)));
      send_word(scs_pkg::OpRun, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_idle_pct = 14;
    recv_idle_pct = 88;
    test_overflow();
    test_random(3);
    wait_drained();                          // sender holds off until drained
    send_idle_pct = 88;
    recv_idle_pct = 14;
    test_random(3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(2);
    wait_drained();
    repeat (200) @(posedge clk);
    $display("Covered %0d runs and %0d output words, including empty, full and",
             runs_sent, words_checked);
    $display("overflowing strings under three idle patterns.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/scs_pkg.sv
hdl/scs_ram.sv
hdl/scs_datapath.sv
hdl/scs_ctrl.sv
hdl/shortest_common_supersequence_core.sv
tb/testbench.sv
